// ===== rtl/core/button_click_classifier_assert.svh =====
// Assertion macros shared by the button click classifier modules.
// Needs nothing else; included by every file that carries assertions.
`ifndef BUTTON_CLICK_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BCC_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcc assertion failed");

// Next-cycle implication, checked outside reset
`define BCC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcc assertion failed");

`endif

// ===== rtl/core/bcc_pkg.sv =====
// Shared types and constants of the button click classifier.
// No dependencies; imported by bcc_lane, bcc_merge and the top level.
package bcc_pkg;

  // Default sizes
  localparam int NUM_BUTTONS_DEF = 3;
  localparam int COUNT_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int PIN_COUNT   = 3;
  localparam int INDEX_WIDTH = 2;
  localparam int EVENT_WIDTH = 3;
  localparam int INTV_WIDTH  = 8;
  localparam int LIMIT_WIDTH = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 8;

  // Release with a running window of this length or less counts as first click
  localparam logic [LIMIT_WIDTH-1:0] SINGLE_MARK = 16'd1;

  // Register reset values
  localparam logic [INTV_WIDTH-1:0]  RST_CHECK_INTERVAL = 8'd10;
  localparam logic [LIMIT_WIDTH-1:0] RST_HOLD_LIMIT     = 16'd100;
  localparam logic [LIMIT_WIDTH-1:0] RST_DC_WINDOW      = 16'd60;
  localparam logic                   RST_ACTIVE_LEVEL   = 1'b0;
  localparam logic                   RST_DC_ENABLE      = 1'b1;
  localparam logic                   RST_HOLD_ENABLE    = 1'b1;
  localparam logic [PIN_COUNT-1:0]   RST_BUTTON_MASK    = 3'b111;

  typedef enum logic [EVENT_WIDTH-1:0] {
    EV_OPEN     = 3'd0,
    EV_HELD     = 3'd1,
    EV_RELEASED = 3'd2,
    EV_CLICKED  = 3'd3,
    EV_DOUBLE   = 3'd4
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHECK_INTERVAL = 3'd0,
    REG_HOLD_LIMIT     = 3'd1,
    REG_DC_WINDOW      = 3'd2,
    REG_ACTIVE_LEVEL   = 3'd3,
    REG_DC_ENABLE      = 3'd4,
    REG_HOLD_ENABLE    = 3'd5,
    REG_BUTTON_MASK    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [INTV_WIDTH-1:0]  check_interval;
    logic [LIMIT_WIDTH-1:0] hold_limit;
    logic [LIMIT_WIDTH-1:0] dc_window;
    logic                   active_level;
    logic                   dc_enable;
    logic                   hold_enable;
    logic [PIN_COUNT-1:0]   button_mask;
  } cfg_t;

  // Per-lane strobes from the top level
  typedef struct packed {
    logic check;   // periodic check of this button
    logic level;   // pin level sampled with the check
    logic clear;   // event read out of this button
  } lane_ctrl_t;

endpackage

// ===== rtl/core/bcc_lane.sv =====
// One button lane: down counter, double-click window and pending event.
// Depends on bcc_pkg and button_click_classifier_assert.svh.
`include "button_click_classifier_assert.svh"

module bcc_lane import bcc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  lane_ctrl_t ctrl,
  output event_t     button_event
);

  localparam int CmpW = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
  localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);

  logic [COUNT_WIDTH-1:0] down_count, down_count_next;
  logic [COUNT_WIDTH-1:0] window_count, window_count_next;
  event_t                 event_state, event_state_next;
  logic                   pressed;
  logic [LIMIT_WIDTH-1:0] window_load;

  assign pressed     = (ctrl.level == cfg.active_level);
  assign window_load = cfg.dc_enable ? cfg.dc_window : SINGLE_MARK;

  // Check and read-clear update
  always_comb begin
    down_count_next   = down_count;
    window_count_next = window_count;
    event_state_next  = event_state;
    if (ctrl.check) begin
      if (pressed) begin
        if (down_count != CountMax) down_count_next = down_count + CountOne;
        if ((CmpW'(down_count_next) > CmpW'(cfg.hold_limit)) && cfg.hold_enable)
          event_state_next = EV_HELD;
      end else begin
        if (down_count > CountOne) begin
          if (event_state == EV_HELD) begin
            event_state_next  = EV_RELEASED;
            window_count_next = '0;
          end else if (CmpW'(window_count) > CmpW'(SINGLE_MARK)) begin
            if (CmpW'(window_count) < CmpW'(cfg.dc_window)) begin
              event_state_next  = EV_DOUBLE;
              window_count_next = '0;
            end
          end else if (CmpW'(window_load) > CmpW'(CountMax)) begin
            window_count_next = CountMax;
          end else begin
            window_count_next = COUNT_WIDTH'(window_load);
          end
        end
        down_count_next = '0;
      end
      // Window countdown; expiry reports a single click
      if (window_count_next != '0) begin
        if (window_count_next == CountOne) event_state_next = EV_CLICKED;
        window_count_next = window_count_next - CountOne;
      end
    end else if (ctrl.clear) begin
      if (event_state != EV_HELD && event_state != EV_OPEN) event_state_next = EV_OPEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down_count   <= '0;
      window_count <= '0;
      event_state  <= EV_OPEN;
    end else begin
      down_count   <= down_count_next;
      window_count <= window_count_next;
      event_state  <= event_state_next;
    end
  end

  assign button_event = event_state;

  `BCC_ASSERT_NEXT(a_idle_frozen, clk, rst, !ctrl.check && !ctrl.clear,
    $stable(down_count) && $stable(window_count) && $stable(event_state))
  `BCC_ASSERT_NEXT(a_read_keeps_held, clk, rst,
    !ctrl.check && ctrl.clear && event_state == EV_HELD, event_state == EV_HELD)
  `BCC_ASSERT_NEXT(a_down_saturates, clk, rst,
    ctrl.check && pressed && down_count == CountMax, down_count == CountMax)

endmodule

// ===== rtl/core/bcc_merge.sv =====
// Merge stage: picks the read button's event and buffers results (two slots).
// Depends on bcc_pkg and button_click_classifier_assert.svh.
`include "button_click_classifier_assert.svh"

module bcc_merge import bcc_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rd_push,
  input  logic [INDEX_WIDTH-1:0] rd_index,
  input  event_t                 lane_event [NUM_BUTTONS],
  output logic                   in_ready,
  output logic                   out_valid,
  output event_t                 out_event,
  input  logic                   out_ready
);

  event_t sel_event;
  event_t skid_event;
  logic   skid_valid;
  logic   take;

  // Index select; an index past the last button reads open
  always_comb begin
    sel_event = EV_OPEN;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (32'(rd_index) == 32'(i)) sel_event = lane_event[i];
    end
  end

  assign take     = out_valid && out_ready;
  assign in_ready = !skid_valid;

  // Output register plus skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_event  <= skid_event;
        skid_valid <= 1'b0;
      end else if (rd_push) begin
        out_event <= sel_event;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (rd_push) begin
      if (!out_valid) begin
        out_event <= sel_event;
        out_valid <= 1'b1;
      end else begin
        skid_event <= sel_event;
        skid_valid <= 1'b1;
      end
    end
  end

  `BCC_ASSERT_IMP(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `BCC_ASSERT_NEXT(a_stall_fills_skid, clk, rst, rd_push && out_valid && !out_ready,
    skid_valid)
  `BCC_ASSERT_IMP(a_no_push_when_full, clk, rst, skid_valid, !rd_push)

endmodule

// ===== rtl/core/button_click_classifier.sv =====
// Top level of the button click classifier: config registers, check interval
// counter, one bcc_lane per button and the bcc_merge output stage. Uses bcc_pkg.
//
// The block takes one transaction per clock cycle while s_axis_tready is high.
// A tick (tuser = 0) carries the pin levels, gives no result, and every
// check_interval ticks runs the check on all enabled buttons at once, one lane
// per button. A read (tuser = 1) returns the chosen button's event on the master
// side and clears it unless it is held; an index past the last button returns
// open. Results go through an output register and a skid slot, so s_axis_tready
// drops only when two read results are waiting. Configuration writes take effect
// in the cycle after they are accepted; cfg_ready is always high.
module button_click_classifier import bcc_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // slave side
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [2:0] pin_levels, [4:3] button_index
  input  logic                  s_axis_tuser,   // [0] cmd
  // master side
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [2:0] button_event
  // configuration write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                   cfg;
  logic [INTV_WIDTH-1:0]  interval_count;
  logic                   accept, tick, read, check_now;
  logic [PIN_COUNT-1:0]   pin_levels;
  logic [INDEX_WIDTH-1:0] button_index;
  event_t                 lane_event [NUM_BUTTONS];
  event_t                 out_event;

  assign pin_levels   = s_axis_tdata[PIN_COUNT-1:0];
  assign button_index = s_axis_tdata[PIN_COUNT+INDEX_WIDTH-1:PIN_COUNT];
  assign accept       = s_axis_tvalid && s_axis_tready;
  assign tick         = accept && !s_axis_tuser;
  assign read         = accept && s_axis_tuser;
  assign cfg_ready    = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_interval <= RST_CHECK_INTERVAL;
      cfg.hold_limit     <= RST_HOLD_LIMIT;
      cfg.dc_window      <= RST_DC_WINDOW;
      cfg.active_level   <= RST_ACTIVE_LEVEL;
      cfg.dc_enable      <= RST_DC_ENABLE;
      cfg.hold_enable    <= RST_HOLD_ENABLE;
      cfg.button_mask    <= RST_BUTTON_MASK;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_CHECK_INTERVAL: cfg.check_interval <= cfg_data[INTV_WIDTH-1:0];
        REG_HOLD_LIMIT:     cfg.hold_limit     <= cfg_data[LIMIT_WIDTH-1:0];
        REG_DC_WINDOW:      cfg.dc_window      <= cfg_data[LIMIT_WIDTH-1:0];
        REG_ACTIVE_LEVEL:   cfg.active_level   <= cfg_data[0];
        REG_DC_ENABLE:      cfg.dc_enable      <= cfg_data[0];
        REG_HOLD_ENABLE:    cfg.hold_enable    <= cfg_data[0];
        REG_BUTTON_MASK:    cfg.button_mask    <= cfg_data[PIN_COUNT-1:0];
        default: ;
      endcase
    end
  end

  // Check interval counter; a zero interval checks on every tick
  assign check_now = (({1'b0, interval_count} + 9'd1) >= {1'b0, cfg.check_interval});

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_count <= '0;
    end else if (tick) begin
      if (check_now) interval_count <= '0;
      else           interval_count <= interval_count + 8'd1;
    end
  end

  // Button lanes; buttons past the pin field are never checked
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    lane_ctrl_t ctrl;
    if (b < PIN_COUNT) begin : g_pin
      assign ctrl.check = tick && check_now && cfg.button_mask[b];
      assign ctrl.level = pin_levels[b];
    end else begin : g_nopin
      assign ctrl.check = 1'b0;
      assign ctrl.level = 1'b0;
    end
    assign ctrl.clear = read && (32'(button_index) == 32'(b));

    bcc_lane #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk          (clk),
      .rst          (rst),
      .cfg          (cfg),
      .ctrl         (ctrl),
      .button_event (lane_event[b])
    );
  end

  bcc_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .rd_push    (read),
    .rd_index   (button_index),
    .lane_event (lane_event),
    .in_ready   (s_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_event  (out_event),
    .out_ready  (m_axis_tready)
  );

  assign m_axis_tdata = {(OUT_DATA_W-EVENT_WIDTH)'(0), out_event};

endmodule

// ===== test/button_click_classifier_tb.sv =====
// Self-checking testbench for button_click_classifier: directed and random tick/read streams
// with a built-in predictor of the per-button click, hold and double-click logic.
// Depends on bcc_pkg and the button_click_classifier RTL; nothing else.
module button_click_classifier_tb;
  import bcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_HALF    = 10;
  localparam int          LIMIT       = 400000;
  localparam int          HOLD_OFF    = 200;
  localparam int unsigned CNT_MAX     = (1 << COUNT_WIDTH_DEF) - 1;
  localparam logic        CMD_TICK    = 1'b0;
  localparam logic        CMD_READ    = 1'b1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [2:0] pin_levels, [4:3] button_index
  logic                  s_axis_tuser = 1'b0; // [0] cmd
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // [2:0] button_event
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  button_click_classifier dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Traffic shaping knobs, set by the test tasks
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit rx_hold_req = 1'b0;

  // Bookkeeping
  int errors = 0;
  int cycles = 0;
  int ticks_sent = 0;
  int reads_sent = 0;
  int results_seen = 0;
  int settings_used = 0;
  int kind_seen [5];

  // Predictor state: configuration and per-button counters
  cfg_t        model_cfg;
  int unsigned tick_count;
  int unsigned down_cnt [NUM_BUTTONS_DEF];
  int unsigned win_cnt [NUM_BUTTONS_DEF];
  event_t      ev_state [NUM_BUTTONS_DEF];
  event_t      expected_events [$];

  // Gesture generator state per button
  bit          btn_down [NUM_BUTTONS_DEF];
  int unsigned btn_ticks_left [NUM_BUTTONS_DEF];

  function automatic void reset_predictor();
    model_cfg.check_interval = RST_CHECK_INTERVAL;
    model_cfg.hold_limit     = RST_HOLD_LIMIT;
    model_cfg.dc_window      = RST_DC_WINDOW;
    model_cfg.active_level   = RST_ACTIVE_LEVEL;
    model_cfg.dc_enable      = RST_DC_ENABLE;
    model_cfg.hold_enable    = RST_HOLD_ENABLE;
    model_cfg.button_mask    = RST_BUTTON_MASK;
    tick_count = 0;
    for (int b = 0; b < NUM_BUTTONS_DEF; b++) begin
      down_cnt[b] = 0;
      win_cnt[b]  = 0;
      ev_state[b] = EV_OPEN;
    end
  endfunction

  // One periodic check of one button
  function automatic void check_one_button(int b, logic level);
    int unsigned w;
    if (level == model_cfg.active_level) begin
      if (down_cnt[b] < CNT_MAX) down_cnt[b]++;
      if (down_cnt[b] > model_cfg.hold_limit && model_cfg.hold_enable) ev_state[b] = EV_HELD;
    end else begin
      if (down_cnt[b] > 1) begin
        if (ev_state[b] == EV_HELD) begin
          ev_state[b] = EV_RELEASED;
          win_cnt[b]  = 0;
        end else if (win_cnt[b] > SINGLE_MARK) begin
          // second release inside the window
          if (win_cnt[b] < model_cfg.dc_window) begin
            ev_state[b] = EV_DOUBLE;
            win_cnt[b]  = 0;
          end
        end else begin
          w = model_cfg.dc_enable ? int'(model_cfg.dc_window) : int'(SINGLE_MARK);
          win_cnt[b] = (w > CNT_MAX) ? CNT_MAX : w;
        end
      end
      down_cnt[b] = 0;
    end
    if (win_cnt[b] > 0) begin
      win_cnt[b]--;
      if (win_cnt[b] == 0) ev_state[b] = EV_CLICKED;
    end
  endfunction

  function automatic void classify_tick(logic [PIN_COUNT-1:0] pins);
    if (tick_count + 1 >= model_cfg.check_interval) begin
      tick_count = 0;
      for (int b = 0; b < NUM_BUTTONS_DEF; b++)
        if (model_cfg.button_mask[b]) check_one_button(b, pins[b]);
    end else begin
      tick_count++;
    end
  endfunction

  function automatic event_t read_button(logic [INDEX_WIDTH-1:0] idx);
    event_t ev;
    ev = EV_OPEN;
    if (idx < NUM_BUTTONS_DEF) begin
      ev = ev_state[idx];
      if (ev != EV_HELD && ev != EV_OPEN) ev_state[idx] = EV_OPEN;
    end
    return ev;
  endfunction

  task automatic report_mismatch(string what, logic [EVENT_WIDTH-1:0] got,
                                 logic [EVENT_WIDTH-1:0] want);
    $display("%0t ns  MISMATCH %s: got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               expected_events.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stalls plus an occasional long hold-off counted here
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = HOLD_OFF;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin : check_results
    event_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tdata[EVENT_WIDTH-1:0] <= EV_DOUBLE) kind_seen[m_axis_tdata[EVENT_WIDTH-1:0]]++;
      if (expected_events.size() == 0) begin
        report_mismatch("result with no read pending", m_axis_tdata[EVENT_WIDTH-1:0], 'x);
      end else begin
        want = expected_events.pop_front();
        if (m_axis_tdata[EVENT_WIDTH-1:0] !== want)
          report_mismatch("button_event", m_axis_tdata[EVENT_WIDTH-1:0], want);
      end
    end
  end

  // Send one transaction on the slave side, predicting on acceptance
  task automatic send_item(logic cmd, logic [PIN_COUNT-1:0] pins,
                           logic [INDEX_WIDTH-1:0] idx);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_DATA_W-PIN_COUNT-INDEX_WIDTH){1'b0}}, idx, pins};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (cmd == CMD_READ) begin
      reads_sent++;
      expected_events.push_back(read_button(idx));
    end else begin
      ticks_sent++;
      classify_tick(pins);
    end
  endtask

  task automatic send_tick(logic [PIN_COUNT-1:0] pins);
    send_item(CMD_TICK, pins, INDEX_WIDTH'($urandom_range(3)));
  endtask

  task automatic send_read(logic [INDEX_WIDTH-1:0] idx);
    send_item(CMD_READ, PIN_COUNT'($urandom_range(7)), idx);
  endtask

  // Hold the given buttons down (others up) for n ticks
  task automatic press(logic [PIN_COUNT-1:0] down, int n);
    repeat (n) send_tick(model_cfg.active_level ? down : ~down);
  endtask

  task automatic wait_drained();
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all seven registers while the block is idle
  task automatic apply_settings(cfg_t c);
    reg_idx_t            r;
    logic [CFG_DATA_W-1:0] v;
    s_axis_tvalid <= 1'b0;
    wait_drained();
    r = REG_CHECK_INTERVAL;
    repeat (r.num()) begin
      case (r)
        REG_CHECK_INTERVAL: v = CFG_DATA_W'(c.check_interval);
        REG_HOLD_LIMIT:     v = c.hold_limit;
        REG_DC_WINDOW:      v = c.dc_window;
        REG_ACTIVE_LEVEL:   v = CFG_DATA_W'(c.active_level);
        REG_DC_ENABLE:      v = CFG_DATA_W'(c.dc_enable);
        REG_HOLD_ENABLE:    v = CFG_DATA_W'(c.hold_enable);
        default:            v = CFG_DATA_W'(c.button_mask);
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data  <= v;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (r)
        REG_CHECK_INTERVAL: model_cfg.check_interval = v[INTV_WIDTH-1:0];
        REG_HOLD_LIMIT:     model_cfg.hold_limit     = v;
        REG_DC_WINDOW:      model_cfg.dc_window      = v;
        REG_ACTIVE_LEVEL:   model_cfg.active_level   = v[0];
        REG_DC_ENABLE:      model_cfg.dc_enable      = v[0];
        REG_HOLD_ENABLE:    model_cfg.hold_enable    = v[0];
        default:            model_cfg.button_mask    = v[PIN_COUNT-1:0];
      endcase
      r = r.next();
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    // Restart gestures so their lengths follow the new timings
    for (int b = 0; b < NUM_BUTTONS_DEF; b++) btn_ticks_left[b] = 0;
    settings_used++;
  endtask

  function automatic cfg_t make_settings(int interval, int hold, int window, bit level,
                                         bit dc_en, bit hold_en, int mask);
    cfg_t c;
    c.check_interval = INTV_WIDTH'(interval);
    c.hold_limit     = LIMIT_WIDTH'(hold);
    c.dc_window      = LIMIT_WIDTH'(window);
    c.active_level   = level;
    c.dc_enable      = dc_en;
    c.hold_enable    = hold_en;
    c.button_mask    = PIN_COUNT'(mask);
    return c;
  endfunction

  // Small timings so that clicks, holds and windows all happen within a phase
  function automatic cfg_t random_settings();
    return make_settings($urandom_range(4), $urandom_range(6), $urandom_range(8),
                         1'($urandom_range(1)), $urandom_range(3) != 0,
                         $urandom_range(3) != 0,
                         ($urandom_range(2) != 0) ? 7 : $urandom_range(7));
  endfunction

  // Length in ticks of the next press or gap of one button
  function automatic int unsigned gesture_ticks(bit going_down);
    int unsigned checks;
    int unsigned step;
    step = (model_cfg.check_interval == 0) ? 1 : model_cfg.check_interval;
    if (going_down) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: checks = $urandom_range(2, 1);                    // click
        5, 6, 7:       checks = model_cfg.hold_limit + $urandom_range(3, 1); // hold
        default:       checks = 1;                                       // bounce
      endcase
    end else begin
      // gaps inside and outside the double-click window
      if ($urandom_range(1)) checks = $urandom_range(model_cfg.dc_window + 1, 1);
      else checks = model_cfg.dc_window + $urandom_range(4);
    end
    if (step > 1 && $urandom_range(3) == 0) return checks * step + $urandom_range(step - 1);
    return checks * step;
  endfunction

  // Press/release gestures with random reads and some pin noise
  task automatic run_gestures(int count);
    logic [PIN_COUNT-1:0] pins;
    repeat (count) begin
      if ($urandom_range(99) < 30) begin
        send_read(INDEX_WIDTH'($urandom_range(3)));
      end else begin
        for (int b = 0; b < NUM_BUTTONS_DEF; b++) begin
          if (btn_ticks_left[b] == 0) begin
            btn_down[b] = !btn_down[b];
            btn_ticks_left[b] = gesture_ticks(btn_down[b]);
          end
          btn_ticks_left[b]--;
          pins[b] = btn_down[b] ? model_cfg.active_level : !model_cfg.active_level;
          if ($urandom_range(19) == 0) pins[b] = !pins[b];
        end
        send_tick(pins);
      end
    end
  endtask

  // ---- test tasks ----

  // Reads after reset, including the index past the last button
  task automatic test_reset_state();
    for (int i = 0; i < 4; i++) send_read(INDEX_WIDTH'(i));
    send_tick(3'b000);
    send_tick(3'b111);
  endtask

  // Zero check interval: hold on every button, read twice, then release
  task automatic test_hold_release();
    apply_settings(make_settings(0, 2, 4, 0, 1, 1, 7));
    press(3'b111, 3);
    send_read(0);
    send_read(0);
    press(3'b000, 1);
    send_read(0);
    send_read(0);
    send_read(1);
    send_read(2);
  endtask

  // Single-click mode, window of one, and window of zero
  task automatic test_click_modes();
    apply_settings(make_settings(1, 5, 6, 0, 0, 1, 7));
    press(3'b001, 2);
    press(3'b000, 1);
    send_read(0);
    apply_settings(make_settings(1, 5, 1, 0, 1, 1, 7));
    press(3'b010, 2);
    press(3'b000, 1);
    send_read(1);
    apply_settings(make_settings(1, 5, 0, 0, 1, 1, 7));
    press(3'b100, 2);
    press(3'b000, 3);
    send_read(2);
  endtask

  // Two quick clicks, then a single click left to expire, active-high pins
  task automatic test_double_click();
    apply_settings(make_settings(1, 5, 6, 1, 1, 1, 7));
    press(3'b001, 2);
    press(3'b000, 1);
    press(3'b001, 2);
    press(3'b000, 1);
    send_read(0);
    press(3'b010, 2);
    press(3'b000, 8);
    send_read(1);
  endtask

  // A masked button keeps its state frozen but can still be read
  task automatic test_disabled_button();
    apply_settings(make_settings(1, 2, 3, 0, 1, 0, 3'b101));
    press(3'b111, 6);
    press(3'b000, 4);
    send_read(1);
    send_read(0);
  endtask

  // Largest and smallest register values
  task automatic test_extreme_settings();
    apply_settings(make_settings(255, 65535, 65535, 1, 1, 1, 7));
    run_gestures(20);
    apply_settings(make_settings(0, 0, 0, 0, 1, 1, 7));
    run_gestures(30);
    apply_settings(make_settings(1, 65535, 65535, 0, 1, 1, 7));
    run_gestures(20);
  endtask

  // Long receiver hold-off fills the output stage; then a full drain pause
  task automatic test_backpressure();
    apply_settings(make_settings(1, 2, 4, 0, 1, 1, 7));
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold_req = 1'b1;
    repeat (2) @(posedge clk);
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 0) press(i[0] ? 3'b111 : 3'b000, 1);
      else send_read(INDEX_WIDTH'($urandom_range(3)));
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();
    run_gestures(15);
  endtask

  // Random gestures under several traffic shapes and settings
  task automatic test_random_phases();
    int idle_mode [4];
    int stall_mode [4];
    idle_mode  = '{0, 70, 0, 6};
    stall_mode = '{0, 0, 70, 6};
    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  = idle_mode[p];
      rx_stall_pct = stall_mode[p];
      repeat (2) begin
        apply_settings(random_settings());
        run_gestures(45);
      end
    end
  endtask

  // Main sequence
  initial begin
    reset_predictor();
    for (int b = 0; b < NUM_BUTTONS_DEF; b++) begin
      btn_down[b] = 1'b0;
      btn_ticks_left[b] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_hold_release();
    test_click_modes();
    test_double_click();
    test_disabled_button();
    test_extreme_settings();
    test_backpressure();
    test_random_phases();

    // Drain and close out
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_events.size() != 0)
      report_mismatch("read result never arrived", 'x, expected_events[0]);
    $display("Covered %0d ticks and %0d reads over %0d register settings, %0d results checked",
             ticks_sent, reads_sent, settings_used, results_seen);
    $display("Events returned: open %0d, held %0d, released %0d, clicked %0d, double %0d",
             kind_seen[EV_OPEN], kind_seen[EV_HELD], kind_seen[EV_RELEASED],
             kind_seen[EV_CLICKED], kind_seen[EV_DOUBLE]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
